### sv/prq_pkg.sv
// Package for the priority ready queue scheduler: payload types and codes.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

  localparam int unsigned TidW = 4;
  localparam int unsigned LvlW = 8;

  // task ids fill the whole id field, levels the whole level field
  localparam int unsigned MaxTaskCount = 16;
  localparam int unsigned LowestLevel  = 255;

  typedef enum logic [1:0] {
    ActInsert   = 2'd0,
    ActRemove   = 2'd1,
    ActSchedule = 2'd2,
    ActNop      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StSwitched = 2'd1,
    StEmpty    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [TidW-1:0] task_id;
    logic [LvlW-1:0] priority_req;
    logic            current_leaving;
    logic            yield_request;
  } in_item_t;

  typedef struct packed {
    logic [TidW-1:0] next_task;
    logic [LvlW-1:0] next_priority;
    logic [1:0]      status;
  } out_item_t;

  typedef enum logic [3:0] {
    SIdle,
    SHeadRd,
    SDecide,
    SWalkRd,
    SWalk,
    SScanRd,
    SScan,
    SAppendRd,
    SAppend,
    SOut
  } state_e;

endpackage
`default_nettype wire

### sv/priority_ready_queue_scheduler_top.sv
// Top level of the priority ready queue scheduler with its sequencer.
//
//  channel | signals                     | role
//  in      | in_valid_i/in_ready_o/in_i  | one operation word
//  out     | out_valid_o/out_ready_i/out_o | one result word per operation
//
// Every operation passes SHeadRd and ends in SOut. Insert adds SAppendRd and SAppend;
// no operation and schedule without a switch add nothing; schedule with a switch
// adds SDecide, and SAppendRd and SAppend when the running task is queued again;
// remove of a queued task adds SWalkRd and a walk of SWalk along the links (up to MaxTaskCount links).
// A list that empties at the top level adds a scan of the head valid bits, one
// level a cycle over at most LowestLevel + 1 levels, and then the SScan state.
// Head valid bits reset at once; other stores are read only where written.
// in_ready_o is low while an operation is in work; the result word holds in the
// output register until taken.
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_queue_scheduler_top (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_ready_o,
  input  prq_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  wire                logic out_ready_i,
  output prq_pkg::out_item_t out_o
);
  import prq_pkg::*;

  localparam int unsigned NLvl = LowestLevel + 1;
  localparam int unsigned TW   = TidW;
  localparam logic [LvlW-1:0] LowLvl = LvlW'(LowestLevel);

  // head memory (tid), tail memory, link and level stores
  logic [TW-1:0]   head_mem [NLvl];
  logic [TW-1:0]   tail_mem [NLvl];
  logic [NLvl-1:0] head_v_q, head_v_d;
  logic [TW-1:0]   link_q [MaxTaskCount];
  logic [MaxTaskCount-1:0] link_v_q;
  logic [LvlW-1:0] tlev_q [MaxTaskCount];
  logic [MaxTaskCount-1:0] queued_q;

  state_e          state_q, state_d;
  in_item_t        it_q;
  logic [LvlW-1:0] lv_q, top_q, top_d, cur_q, cur_d, fl_q, fl_d;
  logic [TW-1:0]   prev_q, prev_d;
  logic [TW-1:0]   head_rd_q, tail_rd_q;
  logic [LvlW-1:0] rd_addr;
  logic [TidW:0]   steps_q, steps_d;
  out_item_t       res_q, res_d;
  logic            out_v_q;

  logic            tid_ok;
  logic [TW-1:0]   tid;
  assign tid    = it_q.task_id;
  assign tid_ok = 32'(tid) < MaxTaskCount;

  // read address for head/tail memory
  always_comb begin
    rd_addr = cur_q;
  end

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[rd_addr];
    tail_rd_q <= tail_mem[rd_addr];
  end

  logic act_in;
  assign act_in = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == SIdle) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = res_q;

  // write controls
  logic            hw_en, tw_en, lk_en, lkv_clr, q_set, q_clr, tl_en;
  logic [LvlW-1:0] hw_addr, tw_addr;
  logic [TW-1:0]   hw_data, tw_data, lk_idx, lk_data, q_idx;
  logic            lkv_val;

  logic want;
  assign want = it_q.current_leaving ||
                (it_q.yield_request && lv_q == top_q) || lv_q > top_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (act_in) state_d = SHeadRd;
      SHeadRd: begin
        unique case (action_e'(it_q.action))
          ActInsert:   state_d = SAppendRd;
          ActRemove:   state_d = (!tid_ok || !queued_q[tid]) ? SOut : SWalkRd;
          ActSchedule: state_d = (want && head_v_q[top_q]) ? SDecide : SOut;
          default:     state_d = SOut;
        endcase
      end
      SDecide: begin
        if (!link_v_q[head_rd_q]) state_d = SScanRd;
        else state_d = it_q.current_leaving ? SOut : SAppendRd;
      end
      SWalkRd: state_d = SWalk;
      SWalk: begin
        if (steps_q == '0) begin
          if (!head_v_q[fl_q]) state_d = SOut;
          else if (head_rd_q == tid) begin
            state_d = (!link_v_q[tid] && fl_q == top_q) ? SScanRd : SOut;
          end
        end else if (32'(steps_q) > MaxTaskCount || !link_v_q[prev_q]) begin
          state_d = SOut;
        end else if (link_q[prev_q] == tid) begin
          state_d = SOut;
        end
      end
      SScanRd: if (head_v_q[cur_q] || cur_q == LowLvl) state_d = SScan;
      SScan: begin
        if (action_e'(it_q.action) == ActSchedule && !it_q.current_leaving) begin
          state_d = SAppendRd;
        end else state_d = SOut;
      end
      SAppendRd: state_d = SAppend;
      SAppend: state_d = SOut;
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    head_v_d = head_v_q;
    top_d = top_q; cur_d = cur_q; fl_d = fl_q;
    prev_d = prev_q; steps_d = steps_q; res_d = res_q;
    hw_en = 1'b0; tw_en = 1'b0; lk_en = 1'b0; lkv_clr = 1'b0;
    q_set = 1'b0; q_clr = 1'b0; tl_en = 1'b0;
    hw_addr = cur_q; tw_addr = cur_q; hw_data = '0; tw_data = tid;
    lk_idx = '0; lk_data = '0; q_idx = tid; lkv_val = 1'b0;
    unique case (state_q)
      SIdle: ;
      SHeadRd: begin
        res_d.next_task = tid;
        res_d.next_priority = '0;
        res_d.status = StDone;
        unique case (action_e'(it_q.action))
          ActInsert: begin
            res_d.next_priority = lv_q;
            cur_d = lv_q;
          end
          ActRemove: begin
            if (!tid_ok || !queued_q[tid]) begin
              res_d.status = StNotFound;
            end else begin
              cur_d = tlev_q[tid];
              fl_d = tlev_q[tid];
              res_d.next_priority = tlev_q[tid];
            end
          end
          ActSchedule: begin
            res_d.next_priority = lv_q;
            if (want && !head_v_q[top_q]) res_d.status = StEmpty;
            else if (want) cur_d = top_q;
          end
          default: ;
        endcase
      end
      SDecide: begin
        // head_rd_q now holds head of top level
        res_d.next_task = head_rd_q;
        res_d.next_priority = top_q;
        res_d.status = StSwitched;
        hw_en = 1'b1; hw_addr = top_q; hw_data = link_q[head_rd_q];
        head_v_d[top_q] = link_v_q[head_rd_q];
        lkv_clr = 1'b1; lk_idx = head_rd_q;
        q_clr = 1'b1; q_idx = head_rd_q;
        fl_d = top_q;
        if (!link_v_q[head_rd_q]) cur_d = top_q;
        else cur_d = lv_q;
      end
      SWalkRd: begin
        steps_d = '0;
        prev_d = head_rd_q; // stale; fixed in SWalk first cycle
      end
      SWalk: begin
        if (steps_q == '0) begin
          prev_d = head_rd_q;
          if (!head_v_q[fl_q]) begin
            res_d.status = StNotFound; res_d.next_priority = '0;
          end else if (head_rd_q == tid) begin
            hw_en = 1'b1; hw_addr = fl_q; hw_data = link_q[tid];
            head_v_d[fl_q] = link_v_q[tid];
            lkv_clr = 1'b1; lk_idx = tid; q_clr = 1'b1;
            if (!link_v_q[tid] && fl_q == top_q) cur_d = fl_q;
          end else steps_d = steps_q + 1'b1;
        end else if (32'(steps_q) > MaxTaskCount || !link_v_q[prev_q]) begin
          res_d.status = StNotFound; res_d.next_priority = '0;
        end else if (link_q[prev_q] == tid) begin
          if (tail_rd_q == tid) begin
            tw_en = 1'b1; tw_addr = fl_q; tw_data = prev_q;
          end
          lk_en = 1'b1; lk_idx = prev_q; lk_data = link_q[tid];
          lkv_val = link_v_q[tid];
          lkv_clr = 1'b1; q_clr = 1'b1;
        end else begin
          prev_d = link_q[prev_q];
          steps_d = steps_q + 1'b1;
        end
      end
      SScanRd: begin
        // scan head valid bits one level a cycle
        if (head_v_q[cur_q]) top_d = cur_q;
        else if (cur_q == LowLvl) top_d = LowLvl;
        else cur_d = cur_q + 1'b1;
      end
      SScan: begin
        if (action_e'(it_q.action) == ActSchedule && !it_q.current_leaving) begin
          cur_d = lv_q;
        end
      end
      SAppendRd: ;
      SAppend: begin
        if (tid_ok && !queued_q[tid]) begin
          if (lv_q < top_q) top_d = lv_q;
          tl_en = 1'b1; q_set = 1'b1;
          lkv_clr = 1'b1; lk_idx = tid;
          if (!head_v_q[lv_q]) begin
            head_v_d[lv_q] = 1'b1;
            hw_en = 1'b1; hw_addr = lv_q; hw_data = tid;
          end else begin
            lk_en = 1'b1; lk_idx = tail_rd_q; lk_data = tid; lkv_val = 1'b1;
            lkv_clr = 1'b0;
          end
          tw_en = 1'b1; tw_addr = lv_q; tw_data = tid;
        end
      end
      SOut: ;
      default: ;
    endcase
  end

  logic [LvlW-1:0] sat_lv;
  assign sat_lv = (32'(in_i.priority_req) > LowestLevel) ? LowLvl : in_i.priority_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      head_v_q <= '0;
      link_v_q <= '0;
      queued_q <= '0;
      top_q    <= LowLvl;
      out_v_q  <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      top_q    <= top_d;
      state_q  <= state_d;
      if (state_q == SOut) out_v_q <= 1'b1;
      else if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (lk_en) link_v_q[lk_idx] <= lkv_val;
      else if (lkv_clr) link_v_q[lk_idx] <= 1'b0;
      if (lk_en && lkv_clr) link_v_q[tid] <= 1'b0;
      if (q_set) queued_q[tid] <= 1'b1;
      if (q_clr) queued_q[q_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_in) begin
      it_q <= in_i;
      lv_q <= sat_lv;
      cur_q <= top_q;
    end else begin
      cur_q <= cur_d;
    end
    fl_q <= fl_d; prev_q <= prev_d; steps_q <= steps_d;
    res_q <= res_d;
    if (hw_en) head_mem[hw_addr] <= hw_data;
    if (tw_en) tail_mem[tw_addr] <= tw_data;
    if (lk_en) link_q[lk_idx] <= lk_data;
    if (tl_en) tlev_q[tid] <= lv_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accepted while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_o)) else $error("result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && head_v_q == '0) |-> top_q == LowLvl)
    else $error("top level not lowest with empty lists");

endmodule
`default_nettype wire
